[rtl/core/page_walk_nx_clear_core_assert.svh]
// Assertion macros shared by the walker RTL.
// PWNC_ASSERT_IMP: same-cycle implication, PWNC_ASSERT_NXT: next-cycle implication.
// Both sample on clk and are disabled while rst_n is low.
`ifndef PAGE_WALK_NX_CLEAR_CORE_ASSERT_SVH
`define PAGE_WALK_NX_CLEAR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PWNC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwnc: same-cycle check failed");
`define PWNC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwnc: next-cycle check failed");
`else
`define PWNC_ASSERT_IMP(lbl, ante, cons)
`define PWNC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/pwnc_pkg.sv]
package pwnc_pkg;

    localparam int PHYS_ADDR_BITS_DEF = 52;
    localparam int ROOT_BITS          = 52;
    localparam int WORD_BITS          = 64;
    localparam int PAGE_SHIFT         = 12;
    localparam int MAX_RES            = 3;

    // entry bit positions
    localparam int NX_BIT = 63;
    localparam int PS_BIT = 7;
    localparam int P_BIT  = 0;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_INVAL = 3'd2,
        OP_DONE  = 3'd3,
        OP_STOP  = 3'd4
    } op_t;

    // level whose entry is outstanding
    typedef enum logic [2:0] {
        LVL_IDLE = 3'd0,
        LVL_1    = 3'd1,
        LVL_2    = 3'd2,
        LVL_3    = 3'd3,
        LVL_4    = 3'd4
    } level_t;

    typedef struct packed {
        level_t                 level;
        logic [WORD_BITS-1:0]   cur_va;
        logic [WORD_BITS-1:0]   end_va;
    } walk_t;

    typedef struct packed {
        op_t                    op;
        logic [WORD_BITS-1:0]   address;
        logic [WORD_BITS-1:0]   write_data;
    } res_t;

endpackage

[rtl/core/pwnc_step.sv]
module pwnc_step #(
    parameter int PHYS_ADDR_BITS = pwnc_pkg::PHYS_ADDR_BITS_DEF
) (
    input  logic                                  req_type,
    input  logic [pwnc_pkg::WORD_BITS-1:0]        start_addr,
    input  logic [pwnc_pkg::WORD_BITS-1:0]        length,
    input  logic [pwnc_pkg::WORD_BITS-1:0]        read_data,
    input  logic [pwnc_pkg::ROOT_BITS-1:0]        table_root,
    input  pwnc_pkg::walk_t                       cur,
    input  logic [PHYS_ADDR_BITS-1:0]             tbl_base,
    input  logic [PHYS_ADDR_BITS-1:0]             entry_addr,
    output pwnc_pkg::walk_t                       nxt,
    output logic [PHYS_ADDR_BITS-1:0]             tbl_base_next,
    output logic [PHYS_ADDR_BITS-1:0]             entry_addr_next,
    output pwnc_pkg::res_t [pwnc_pkg::MAX_RES-1:0] res,
    output logic [1:0]                            res_cnt
);

    localparam int PS = pwnc_pkg::PAGE_SHIFT;
    localparam int WB = pwnc_pkg::WORD_BITS;

    // entry address: table base with bits 11..3 replaced by the level index
    function automatic logic [PHYS_ADDR_BITS-1:0] entry_of(
        input pwnc_pkg::level_t            lvl,
        input logic [PHYS_ADDR_BITS-1:0]   base,
        input logic [WB-1:0]               va
    );
        logic [8:0] idx;
        unique case (lvl)
            pwnc_pkg::LVL_4: idx = va[47:39];
            pwnc_pkg::LVL_3: idx = va[38:30];
            pwnc_pkg::LVL_2: idx = va[29:21];
            default:         idx = va[20:12];
        endcase
        return {base[PHYS_ADDR_BITS-1:PS], idx, 3'b000};
    endfunction

    function automatic logic [WB-1:0] widen(input logic [PHYS_ADDR_BITS-1:0] pa);
        return {{(WB-PHYS_ADDR_BITS){1'b0}}, pa};
    endfunction

    logic [WB-1:0]              s_cur;
    logic [WB-1:0]              s_sum;
    logic [WB-1:0]              s_end;
    logic [WB-PS:0]             pt_sum;
    logic [WB-1:0]              pt_next;
    logic [WB-30:0]             gb_sum;
    logic [WB-21:0]             mb_sum;
    logic                       big_leaf;
    logic                       l_wrap;
    logic [WB-1:0]              l_next;
    logic [PHYS_ADDR_BITS-1:0]  root_base;
    logic [PHYS_ADDR_BITS-1:0]  e_base;
    logic [WB-1:0]              e_clr;

    assign s_cur     = {start_addr[WB-1:PS], {PS{1'b0}}};
    assign s_sum     = start_addr + length + WB'(12'hfff);
    assign s_end     = {s_sum[WB-1:PS], {PS{1'b0}}};
    assign pt_sum    = {1'b0, cur.cur_va[WB-1:PS]} + (WB-PS+1)'(1);
    assign pt_next   = {pt_sum[WB-PS-1:0], {PS{1'b0}}};
    assign gb_sum    = {1'b0, cur.cur_va[WB-1:30]} + (WB-29)'(1);
    assign mb_sum    = {1'b0, cur.cur_va[WB-1:21]} + (WB-20)'(1);
    assign big_leaf  = read_data[pwnc_pkg::PS_BIT]
                       && (cur.level == pwnc_pkg::LVL_3 || cur.level == pwnc_pkg::LVL_2);
    assign l_wrap    = (cur.level == pwnc_pkg::LVL_3) ? gb_sum[WB-30] : mb_sum[WB-21];
    assign l_next    = (cur.level == pwnc_pkg::LVL_3) ? {gb_sum[WB-31:0], 30'b0}
                                                      : {mb_sum[WB-22:0], 21'b0};
    assign root_base = {table_root[PHYS_ADDR_BITS-1:PS], {PS{1'b0}}};
    assign e_base    = {read_data[PHYS_ADDR_BITS-1:PS], {PS{1'b0}}};
    assign e_clr     = {1'b0, read_data[WB-2:0]};

    always_comb
    begin
        logic [1:0]    n;
        logic          goon;
        logic [WB-1:0] gva;

        nxt             = cur;
        tbl_base_next   = tbl_base;
        entry_addr_next = entry_addr;
        res             = '0;
        n               = 2'd0;
        goon            = 1'b0;
        gva             = cur.cur_va;

        if (!req_type)
        begin
            nxt.cur_va = s_cur;
            nxt.end_va = s_end;
            goon       = 1'b1;
            gva        = s_cur;
        end
        else
        begin
            case (cur.level) inside
                pwnc_pkg::LVL_4, pwnc_pkg::LVL_3, pwnc_pkg::LVL_2:
                begin
                    if (!read_data[pwnc_pkg::P_BIT])
                    begin
                        nxt.level = pwnc_pkg::LVL_IDLE;
                        res[n]    = '{op: pwnc_pkg::OP_STOP, address: '0, write_data: '0};
                        n         = n + 2'd1;
                    end
                    else if (big_leaf)
                    begin
                        if (read_data[pwnc_pkg::NX_BIT])
                        begin
                            res[n] = '{op: pwnc_pkg::OP_WRITE, address: widen(entry_addr),
                                       write_data: e_clr};
                            n      = n + 2'd1;
                        end
                        res[n] = '{op: pwnc_pkg::OP_INVAL, address: cur.cur_va,
                                   write_data: '0};
                        n      = n + 2'd1;
                        if (l_wrap)
                        begin
                            nxt.level = pwnc_pkg::LVL_IDLE;
                            res[n]    = '{op: pwnc_pkg::OP_DONE, address: '0, write_data: '0};
                            n         = n + 2'd1;
                        end
                        else
                        begin
                            nxt.cur_va = l_next;
                            goon       = 1'b1;
                            gva        = l_next;
                        end
                    end
                    else
                    begin
                        nxt.level       = pwnc_pkg::level_t'(cur.level - 3'd1);
                        tbl_base_next   = e_base;
                        entry_addr_next = entry_of(nxt.level, e_base, cur.cur_va);
                        res[n] = '{op: pwnc_pkg::OP_READ, address: widen(entry_addr_next),
                                   write_data: '0};
                        n      = n + 2'd1;
                    end
                end
                pwnc_pkg::LVL_1:
                begin
                    if (read_data[pwnc_pkg::P_BIT] && read_data[pwnc_pkg::NX_BIT])
                    begin
                        res[n] = '{op: pwnc_pkg::OP_WRITE, address: widen(entry_addr),
                                   write_data: e_clr};
                        n      = n + 2'd1;
                        res[n] = '{op: pwnc_pkg::OP_INVAL, address: cur.cur_va,
                                   write_data: '0};
                        n      = n + 2'd1;
                    end
                    if (pt_sum[WB-PS])
                    begin
                        nxt.level = pwnc_pkg::LVL_IDLE;
                        res[n]    = '{op: pwnc_pkg::OP_DONE, address: '0, write_data: '0};
                        n         = n + 2'd1;
                    end
                    else
                    begin
                        nxt.cur_va = pt_next;
                        if (pt_next < cur.end_va && pt_next[20:12] != 9'd0)
                        begin
                            // stay in the same page table
                            entry_addr_next = entry_of(pwnc_pkg::LVL_1, tbl_base, pt_next);
                            res[n] = '{op: pwnc_pkg::OP_READ,
                                       address: widen(entry_addr_next), write_data: '0};
                            n      = n + 2'd1;
                        end
                        else
                        begin
                            goon = 1'b1;
                            gva  = pt_next;
                        end
                    end
                end
                default:
                begin
                    nxt.level = pwnc_pkg::LVL_IDLE;
                end
            endcase
        end

        // restart from the top-level table, or finish
        if (goon)
        begin
            if (gva < nxt.end_va)
            begin
                nxt.level       = pwnc_pkg::LVL_4;
                tbl_base_next   = root_base;
                entry_addr_next = entry_of(pwnc_pkg::LVL_4, root_base, gva);
                res[n] = '{op: pwnc_pkg::OP_READ, address: widen(entry_addr_next),
                           write_data: '0};
                n      = n + 2'd1;
            end
            else
            begin
                nxt.level = pwnc_pkg::LVL_IDLE;
                res[n]    = '{op: pwnc_pkg::OP_DONE, address: '0, write_data: '0};
                n         = n + 2'd1;
            end
        end

        res_cnt = n;
    end

endmodule

[rtl/core/pwnc_outq.sv]
`include "page_walk_nx_clear_core_assert.svh"

module pwnc_outq (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  pwnc_pkg::res_t [pwnc_pkg::MAX_RES-1:0] res,
    input  logic [1:0]                            res_cnt,
    output logic                                  ready,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output pwnc_pkg::op_t                         op,
    output logic [pwnc_pkg::WORD_BITS-1:0]        address,
    output logic [pwnc_pkg::WORD_BITS-1:0]        write_data,
    output logic                                  last
);

    pwnc_pkg::res_t slot_reg [pwnc_pkg::MAX_RES];
    logic [1:0]     rem_reg;
    logic [1:0]     rem_next;
    logic [1:0]     ptr_reg;
    logic [1:0]     ptr_next;
    logic           take;

    assign out_valid  = (rem_reg != 2'd0);
    assign take       = out_valid && !out_stall;
    assign ready      = (rem_reg == 2'd0) || (rem_reg == 2'd1 && take);
    assign op         = slot_reg[ptr_reg].op;
    assign address    = slot_reg[ptr_reg].address;
    assign write_data = slot_reg[ptr_reg].write_data;
    assign last       = (rem_reg == 2'd1);

    always_comb
    begin
        rem_next = rem_reg;
        ptr_next = ptr_reg;
        if (load)
        begin
            rem_next = res_cnt;
            ptr_next = 2'd0;
        end
        else if (take)
        begin
            rem_next = rem_reg - 2'd1;
            ptr_next = ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
            ptr_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < pwnc_pkg::MAX_RES; i++)
            begin
                slot_reg[i] <= res[i];
            end
        end
    end

    `PWNC_ASSERT_IMP(a_ptr_bound, 1'b1, ({1'b0, ptr_reg} + {1'b0, rem_reg}) <= 3'd3)
    `PWNC_ASSERT_NXT(a_drain_empty, take && rem_reg == 2'd1 && !load, !out_valid)
    `PWNC_ASSERT_IMP(a_load_free, load, ready)

endmodule

[rtl/core/page_walk_nx_clear_core.sv]
// Page-table walker that clears the no-execute bit over a virtual range.
// Input channel (in_valid / in_stall): req_type 0 starts a range from start_addr and
// length; req_type 1 returns the entry word for the last read in read_data.
// Output channel (out_valid / out_stall): op, address, write_data, last. Each input
// transaction gives zero to three result transactions; last marks the final one.
// The caller performs each read and feeds the entry back as a req_type 1 transaction.
// The caller writes table_root through table_root_we / table_root only while the block is idle; the block itself
// does not enforce this. Each input transaction is held in the input register and its results are registered
// in the result buffer before they are offered. Throughput: one transaction per cycle while each gives at most
// one result and out_stall is low; a transaction with several results holds the result buffer until its last
// result is taken. The rate is set by the three-entry result buffer, which drains one result a cycle while
// out_stall is low. A stall on the output holds the current result; one further input transaction is
// then absorbed in the input register before in_stall rises.
// Reset clears the walk state to idle, table_root to zero and empties both stages;
// there is no clearing pass and the block accepts work from the first cycle.
`include "page_walk_nx_clear_core_assert.svh"

module page_walk_nx_clear_core #(
    parameter int PHYS_ADDR_BITS = pwnc_pkg::PHYS_ADDR_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic [pwnc_pkg::WORD_BITS-1:0]     start_addr,
    input  logic [pwnc_pkg::WORD_BITS-1:0]     length,
    input  logic [pwnc_pkg::WORD_BITS-1:0]     read_data,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output pwnc_pkg::op_t                      op,
    output logic [pwnc_pkg::WORD_BITS-1:0]     address,
    output logic [pwnc_pkg::WORD_BITS-1:0]     write_data,
    output logic                               last,
    // configuration
    input  logic                               table_root_we,
    input  logic [pwnc_pkg::ROOT_BITS-1:0]     table_root
);

    // input register
    logic                               in_vld_reg;
    logic                               in_vld_next;
    logic                               req_type_reg;
    logic [pwnc_pkg::WORD_BITS-1:0]     start_addr_reg;
    logic [pwnc_pkg::WORD_BITS-1:0]     length_reg;
    logic [pwnc_pkg::WORD_BITS-1:0]     read_data_reg;
    logic                               in_take;

    // walk state
    pwnc_pkg::walk_t                    walk_reg;
    pwnc_pkg::walk_t                    walk_next;
    logic [PHYS_ADDR_BITS-1:0]          tbl_base_reg;
    logic [PHYS_ADDR_BITS-1:0]          tbl_base_next;
    logic [PHYS_ADDR_BITS-1:0]          entry_addr_reg;
    logic [PHYS_ADDR_BITS-1:0]          entry_addr_next;
    logic [pwnc_pkg::ROOT_BITS-1:0]     table_root_reg;

    pwnc_pkg::res_t [pwnc_pkg::MAX_RES-1:0] step_res;
    logic [1:0]                         step_cnt;
    logic                               q_ready;
    logic                               proc;

    // an item is processed once the result buffer is, or is about to be, empty
    assign proc        = in_vld_reg && q_ready;
    assign in_stall    = in_vld_reg && !q_ready;
    assign in_take     = in_valid && !in_stall;
    assign in_vld_next = in_take || (in_vld_reg && !proc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            walk_reg       <= '{level: pwnc_pkg::LVL_IDLE, cur_va: '0, end_va: '0};
            tbl_base_reg   <= '0;
            entry_addr_reg <= '0;
            table_root_reg <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (proc)
            begin
                walk_reg       <= walk_next;
                tbl_base_reg   <= tbl_base_next;
                entry_addr_reg <= entry_addr_next;
            end
            if (table_root_we)
            begin
                table_root_reg <= table_root;
            end
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_type_reg   <= req_type;
            start_addr_reg <= start_addr;
            length_reg     <= length;
            read_data_reg  <= read_data;
        end
    end

    pwnc_step #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_step (
        .req_type        (req_type_reg),
        .start_addr      (start_addr_reg),
        .length          (length_reg),
        .read_data       (read_data_reg),
        .table_root      (table_root_reg),
        .cur             (walk_reg),
        .tbl_base        (tbl_base_reg),
        .entry_addr      (entry_addr_reg),
        .nxt             (walk_next),
        .tbl_base_next   (tbl_base_next),
        .entry_addr_next (entry_addr_next),
        .res             (step_res),
        .res_cnt         (step_cnt)
    );

    pwnc_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (proc),
        .res        (step_res),
        .res_cnt    (step_cnt),
        .ready      (q_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .op         (op),
        .address    (address),
        .write_data (write_data),
        .last       (last)
    );

    // done and stop always close a transaction's results
    `PWNC_ASSERT_IMP(a_end_last, out_valid && (op == pwnc_pkg::OP_DONE || op == pwnc_pkg::OP_STOP), last)
    // a pending read means an entry is outstanding
    `PWNC_ASSERT_IMP(a_read_walk, out_valid && op == pwnc_pkg::OP_READ, walk_reg.level != pwnc_pkg::LVL_IDLE)
    // a pending done leaves the walker idle
    `PWNC_ASSERT_IMP(a_done_idle, out_valid && op == pwnc_pkg::OP_DONE, walk_reg.level == pwnc_pkg::LVL_IDLE)

endmodule

[tb/sv/page_walk_nx_clear_checker.sv]
`timescale 1ns / 100ps

module page_walk_nx_clear_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               req_type,
    input  logic [pwnc_pkg::WORD_BITS-1:0]     start_addr,
    input  logic [pwnc_pkg::WORD_BITS-1:0]     length,
    input  logic [pwnc_pkg::WORD_BITS-1:0]     read_data,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  pwnc_pkg::op_t                      op,
    input  logic [pwnc_pkg::WORD_BITS-1:0]     address,
    input  logic [pwnc_pkg::WORD_BITS-1:0]     write_data,
    input  logic                               last,
    input  logic                               table_root_we,
    input  logic [pwnc_pkg::ROOT_BITS-1:0]     table_root,
    output int                                 mismatches,
    output int                                 results_due,
    output int                                 results_seen
);

    localparam int PHYS_BITS = pwnc_pkg::PHYS_ADDR_BITS_DEF;
    localparam logic [pwnc_pkg::WORD_BITS-1:0] PHYS_MASK = (64'd1 << PHYS_BITS) - 64'd1;
    localparam logic [pwnc_pkg::WORD_BITS-1:0] PAGE_OFFS = 64'hfff;
    localparam logic [pwnc_pkg::WORD_BITS-1:0] NX_MASK   = 64'd1 << pwnc_pkg::NX_BIT;

    typedef struct packed {
        pwnc_pkg::op_t                    op;
        logic [pwnc_pkg::WORD_BITS-1:0]   address;
        logic [pwnc_pkg::WORD_BITS-1:0]   write_data;
        logic                             last;
    } walk_result_t;

    // walker state as the block should hold it
    pwnc_pkg::level_t                 walk_lvl;
    logic [pwnc_pkg::WORD_BITS-1:0]   walk_va;
    logic [pwnc_pkg::WORD_BITS-1:0]   walk_end;
    logic [pwnc_pkg::WORD_BITS-1:0]   lvl_base;
    logic [pwnc_pkg::WORD_BITS-1:0]   entry_pa;
    logic [pwnc_pkg::WORD_BITS-1:0]   root_pa;

    walk_result_t           step_out[$];
    walk_result_t           walk_results_due[$];
    int                     mismatch_count;
    int                     seen_count;
    int                     due_count;

    assign mismatches   = mismatch_count;
    assign results_due  = due_count;
    assign results_seen = seen_count;

    task automatic post(input pwnc_pkg::op_t o, input logic [pwnc_pkg::WORD_BITS-1:0] a,
                        input logic [pwnc_pkg::WORD_BITS-1:0] d);
        walk_result_t r;
        r.op         = o;
        r.address    = a;
        r.write_data = d;
        r.last       = 1'b0;
        step_out.push_back(r);
    endtask

    function automatic logic [pwnc_pkg::WORD_BITS-1:0] table_base(
        input logic [pwnc_pkg::WORD_BITS-1:0] word);
        return word & PHYS_MASK & ~PAGE_OFFS;
    endfunction

    task automatic fetch_entry(input pwnc_pkg::level_t lvl,
                               input logic [pwnc_pkg::WORD_BITS-1:0] base);
        int shift;
        shift    = 12 + 9 * (int'(lvl) - 1);
        lvl_base = base;
        entry_pa = (base + (((walk_va >> shift) & 64'h1ff) << 3)) & PHYS_MASK;
        walk_lvl = lvl;
        post(pwnc_pkg::OP_READ, entry_pa, '0);
    endtask

    task automatic restart_or_finish();
        if (walk_va < walk_end)
            fetch_entry(pwnc_pkg::LVL_4, table_base(root_pa));
        else
        begin
            walk_lvl = pwnc_pkg::LVL_IDLE;
            post(pwnc_pkg::OP_DONE, '0, '0);
        end
    endtask

    // 1 GiB / 2 MiB leaf: write only if NX set, always invalidate, then hop on
    task automatic leaf_large(input logic [pwnc_pkg::WORD_BITS-1:0] e, input int shift);
        logic [pwnc_pkg::WORD_BITS-1:0] next_va;
        if (e[pwnc_pkg::NX_BIT])
            post(pwnc_pkg::OP_WRITE, entry_pa, e & ~NX_MASK);
        post(pwnc_pkg::OP_INVAL, walk_va, '0);
        next_va = ((walk_va >> shift) + 64'd1) << shift;
        if (next_va == '0)
        begin
            walk_lvl = pwnc_pkg::LVL_IDLE;
            post(pwnc_pkg::OP_DONE, '0, '0);
        end
        else
        begin
            walk_va = next_va;
            restart_or_finish();
        end
    endtask

    // results caused by one accepted input transaction
    task automatic walk_step(input logic kind, input logic [pwnc_pkg::WORD_BITS-1:0] s,
                             input logic [pwnc_pkg::WORD_BITS-1:0] len,
                             input logic [pwnc_pkg::WORD_BITS-1:0] e);
        walk_result_t r;
        step_out.delete();
        if (!kind)
        begin
            walk_va  = s & ~PAGE_OFFS;
            walk_end = (s + len + PAGE_OFFS) & ~PAGE_OFFS;
            restart_or_finish();
        end
        else
        begin
            case (walk_lvl)
                pwnc_pkg::LVL_4, pwnc_pkg::LVL_3, pwnc_pkg::LVL_2:
                begin
                    if (!e[pwnc_pkg::P_BIT])
                    begin
                        walk_lvl = pwnc_pkg::LVL_IDLE;
                        post(pwnc_pkg::OP_STOP, '0, '0);
                    end
                    else if (walk_lvl == pwnc_pkg::LVL_3 && e[pwnc_pkg::PS_BIT])
                        leaf_large(e, 30);
                    else if (walk_lvl == pwnc_pkg::LVL_2 && e[pwnc_pkg::PS_BIT])
                        leaf_large(e, 21);
                    else
                        fetch_entry(pwnc_pkg::level_t'(walk_lvl - 1), table_base(e));
                end
                pwnc_pkg::LVL_1:
                begin
                    if (e[pwnc_pkg::P_BIT] && e[pwnc_pkg::NX_BIT])
                    begin
                        post(pwnc_pkg::OP_WRITE, entry_pa, e & ~NX_MASK);
                        post(pwnc_pkg::OP_INVAL, walk_va, '0);
                    end
                    walk_va = walk_va + 64'd4096;
                    if (walk_va == '0)
                    begin
                        walk_lvl = pwnc_pkg::LVL_IDLE;
                        post(pwnc_pkg::OP_DONE, '0, '0);
                    end
                    else if (walk_va < walk_end && walk_va[20:12] != 9'd0)
                        fetch_entry(pwnc_pkg::LVL_1, lvl_base);
                    else
                        restart_or_finish();
                end
                default:
                    walk_lvl = pwnc_pkg::LVL_IDLE;
            endcase
        end
        for (int i = 0; i < step_out.size(); i++)
        begin
            r      = step_out[i];
            r.last = (i == step_out.size() - 1);
            walk_results_due.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t got;
        walk_result_t want;
        if (!rst_n)
        begin
            walk_lvl = pwnc_pkg::LVL_IDLE;
            walk_va  = '0;
            walk_end = '0;
            lvl_base = '0;
            entry_pa = '0;
            root_pa  = '0;
            walk_results_due.delete();
            mismatch_count = 0;
            seen_count     = 0;
        end
        else
        begin
            if (table_root_we)
                root_pa = {{(pwnc_pkg::WORD_BITS-pwnc_pkg::ROOT_BITS){1'b0}}, table_root};
            if (in_valid && !in_stall)
                walk_step(req_type, start_addr, length, read_data);
            if (out_valid && !out_stall)
            begin
                got.op         = op;
                got.address    = address;
                got.write_data = write_data;
                got.last       = last;
                seen_count++;
                if (walk_results_due.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result: op %0d addr %h data %h last %b",
                                 got.op, got.address, got.write_data, got.last);
                    mismatch_count++;
                end
                else
                begin
                    want = walk_results_due.pop_front();
                    if (got !== want)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("mismatch: want op %0d addr %h data %h last %b",
                                     want.op, want.address, want.write_data, want.last);
                            $display("          got  op %0d addr %h data %h last %b",
                                     got.op, got.address, got.write_data, got.last);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        due_count = walk_results_due.size();
    end

endmodule

[tb/sv/page_walk_nx_clear_core_tb.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the NX-clearing walker. The checker instance beside
// the block does all prediction; this module plays the caller, answering
// read results with entry words, and shapes the idling on both channels.
module page_walk_nx_clear_core_tb;

    localparam int ROOT_W = pwnc_pkg::ROOT_BITS;

    // entry words used by the directed part
    // present table
    localparam logic [pwnc_pkg::WORD_BITS-1:0] DIR_TABLE = 64'h0000_0000_0003_4003;
    localparam logic [pwnc_pkg::WORD_BITS-1:0] ENTRY_NX  = 64'h8000_0000_0000_0000;
    localparam logic [pwnc_pkg::WORD_BITS-1:0] ENTRY_PS  = 64'h0000_0000_0000_0080;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic                             req_type;
    logic [pwnc_pkg::WORD_BITS-1:0]   start_addr;
    logic [pwnc_pkg::WORD_BITS-1:0]   length;
    logic [pwnc_pkg::WORD_BITS-1:0]   read_data;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    pwnc_pkg::op_t                    op;
    logic [pwnc_pkg::WORD_BITS-1:0]   address;
    logic [pwnc_pkg::WORD_BITS-1:0]   write_data;
    logic                             last;
    logic                             table_root_we;
    logic [pwnc_pkg::ROOT_BITS-1:0]   table_root;

    int                     mismatches;
    int                     results_due;
    int                     results_seen;

    // idling mix, percent of cycles
    int                     send_gap_pct = 17;
    int                     stall_pct    = 46;

    pwnc_pkg::op_t          last_seen_op = pwnc_pkg::OP_DONE;
    int                     walk_items;
    int                     starts_sent;
    int                     entries_sent;

    page_walk_nx_clear_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .start_addr    (start_addr),
        .length        (length),
        .read_data     (read_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .op            (op),
        .address       (address),
        .write_data    (write_data),
        .last          (last),
        .table_root_we (table_root_we),
        .table_root    (table_root)
    );

    page_walk_nx_clear_checker walk_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .start_addr    (start_addr),
        .length        (length),
        .read_data     (read_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .op            (op),
        .address       (address),
        .write_data    (write_data),
        .last          (last),
        .table_root_we (table_root_we),
        .table_root    (table_root),
        .mismatches    (mismatches),
        .results_due   (results_due),
        .results_seen  (results_seen)
    );

    // 4 ns period
    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    // receiver back-pressure, changed on the falling edge only
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    // the caller's view of the walk: a READ as the final result of a
    // transaction means an entry word is now owed to the block
    always @(posedge clk)
        if (out_valid && !out_stall)
            last_seen_op <= op;

    // one input transaction: optional gap, drive on the falling edge, hold
    // until the rising edge that takes it
    task automatic push_item(input logic kind, input logic [pwnc_pkg::WORD_BITS-1:0] s,
                             input logic [pwnc_pkg::WORD_BITS-1:0] len,
                             input logic [pwnc_pkg::WORD_BITS-1:0] e);
        if ($urandom_range(99) < send_gap_pct)
            repeat ($urandom_range(1, 4))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        @(negedge clk);
        in_valid   <= 1'b1;
        req_type   <= kind;
        start_addr <= s;
        length     <= len;
        read_data  <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drop valid and hold off until every predicted result has come back
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
    endtask

    task automatic begin_range(input logic [pwnc_pkg::WORD_BITS-1:0] s,
                               input logic [pwnc_pkg::WORD_BITS-1:0] len);
        push_item(1'b0, s, len, {$urandom, $urandom});
        walk_items++;
        starts_sent++;
        wait_quiet();
    endtask

    task automatic give_entry(input logic [pwnc_pkg::WORD_BITS-1:0] e);
        push_item(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, e);
        walk_items++;
        entries_sent++;
        wait_quiet();
    endtask

    // random entry word: mostly present, some large-page flags, NX half the time
    function automatic logic [pwnc_pkg::WORD_BITS-1:0] make_entry();
        logic [pwnc_pkg::WORD_BITS-1:0] e;
        e                   = {$urandom, $urandom};
        e[pwnc_pkg::P_BIT]  = ($urandom_range(99) < 90);
        e[pwnc_pkg::PS_BIT] = ($urandom_range(99) < 15);
        e[pwnc_pkg::NX_BIT] = 1'($urandom_range(1));
        return e;
    endfunction

    // Finish any walk with an empty range, let the pipe empty, then load a new
    // root. An empty range gives DONE at once and leaves the walker idle.
    task automatic park_and_load(input logic [pwnc_pkg::ROOT_BITS-1:0] root);
        begin_range(64'h5000, 64'd0);
        repeat (4) @(negedge clk);
        table_root_we <= 1'b1;
        table_root    <= root;
        @(negedge clk);
        table_root_we <= 1'b0;
    endtask

    // Mostly well-formed walks: a start, then an entry for every read until the
    // walk ends or the entry budget runs out (the next start then abandons it).
    // Now and then a short burst of unchecked-in-order noise is thrown in.
    task automatic random_walks(input int n);
        int                             target;
        int                             sel;
        int                             budget;
        logic [pwnc_pkg::WORD_BITS-1:0] s;
        logic [pwnc_pkg::WORD_BITS-1:0] len;
        target = walk_items + n;
        while (walk_items < target)
        begin
            sel = $urandom_range(99);
            s   = {$urandom, $urandom};
            len = 64'($urandom_range(0, 5) * 4096 + $urandom_range(0, 4095));
            if (sel >= 70 && sel < 80)
            begin
                // runs over a 2 MiB line
                s[20:12] = 9'h1ff;
                len      = 64'($urandom_range(1, 3) * 4096);
            end
            else if (sel >= 80 && sel < 90)
                s[63:30] = '1;      // last GiB: large leaves wrap the address
            else if (sel >= 90)
                len = {$urandom, $urandom};
            begin_range(s, len);
            budget = $urandom_range(6, 24);
            for (int i = 0; i < budget && last_seen_op == pwnc_pkg::OP_READ; i++)
            begin
                if ($urandom_range(99) < 6)
                begin
                    repeat ($urandom_range(1, 3))
                        push_item(1'($urandom_range(1)), {$urandom, $urandom},
                                  64'($urandom_range(0, 3) * 4096), make_entry());
                    wait_quiet();
                end
                if (last_seen_op == pwnc_pkg::OP_READ)
                    give_entry(make_entry());
            end
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        req_type      <= 1'b0;
        start_addr    <= '0;
        length        <= '0;
        read_data     <= '0;
        table_root_we <= 1'b0;
        table_root    <= '0;
        walk_items    = 0;
        starts_sent   = 0;
        entries_sent  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        park_and_load(ROOT_W'({$urandom, $urandom}));

        // --- directed cases ---
        // entry word with no read outstanding: dropped, no result
        give_entry('1);
        // start and length at their maxima; the end wraps and the range is empty
        begin_range('1, '1);
        // across a 2 MiB line: 4 KiB leaf cleared, restart at the top, all-ones
        // entry at the top level, then a 2 MiB leaf without NX (invalidate only)
        begin_range(64'h1f_f000, 64'h2000);
        give_entry(DIR_TABLE);
        give_entry(DIR_TABLE);
        give_entry(DIR_TABLE);
        give_entry(DIR_TABLE | ENTRY_NX);
        give_entry('1);
        give_entry(DIR_TABLE);
        give_entry(DIR_TABLE | ENTRY_PS);
        // last 2 GiB: 1 GiB leaf with NX, then one that wraps past the top
        begin_range(64'hffff_ffff_8000_0000, 64'h4000_1000);
        give_entry(DIR_TABLE);
        give_entry(DIR_TABLE | ENTRY_PS | ENTRY_NX);
        give_entry(DIR_TABLE);
        give_entry(DIR_TABLE | ENTRY_PS);
        // non-present 4 KiB entry skipped, then a fresh start abandons the walk
        // and a non-present top-level entry stops it
        begin_range(64'h7000, 64'h2000);
        give_entry(DIR_TABLE);
        give_entry(DIR_TABLE);
        give_entry(DIR_TABLE);
        give_entry(64'd0);
        begin_range(64'h10_0000, 64'h1000);
        give_entry(64'd0);
        // non-present entry at the 2 MiB level stops the walk
        begin_range(64'h40_0000, 64'h1000);
        give_entry(DIR_TABLE);
        give_entry(DIR_TABLE);
        give_entry(ENTRY_NX);

        // --- random phases ---
        random_walks(45);
        park_and_load('1);
        send_gap_pct = 46;
        stall_pct    = 17;
        random_walks(40);
        park_and_load('0);
        send_gap_pct = 0;
        stall_pct    = 0;
        random_walks(35);

        wait_quiet();
        repeat (8) @(posedge clk);

        $display("walked %0d ranges with %0d entry words returned; %0d results checked",
                 starts_sent, entries_sent, results_seen);
        $display("roots random, all ones and zero; three sender/receiver idling mixes");
        if (results_due != 0)
            $display("%0d predicted results never arrived", results_due);
        if (mismatches == 0 && results_due == 0)
            $display("== PASS ==");
        else
        begin
            $display("%0d mismatching results", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run (tens of microseconds)
    initial
    begin
        #2000000;
        $display("timeout with %0d results outstanding", results_due);
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/pwnc_pkg.sv
rtl/core/pwnc_step.sv
rtl/core/pwnc_outq.sv
rtl/core/page_walk_nx_clear_core.sv
tb/sv/page_walk_nx_clear_checker.sv
tb/sv/page_walk_nx_clear_core_tb.sv
